// ----- design/assert_macros.svh -----
// shared assertion helpers, clocked on the rising edge and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dhv_pkg.sv -----
package dhv_pkg;

    // phase of the name walk
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_STAR   = 3'd1,
        PH_WILD   = 3'd2,
        PH_FIRST  = 3'd3,
        PH_REST   = 3'd4,
        PH_BROKEN = 3'd5
    } t_phase;

    typedef logic [1:0] t_reason;

    localparam t_reason REASON_OK        = 2'd0;
    localparam t_reason REASON_FORM      = 2'd1;
    localparam t_reason REASON_NAME_LONG = 2'd2;
    localparam t_reason REASON_LABEL_LONG = 2'd3;

    // classified character, as carried from the front end to the back end
    typedef struct packed {
        logic is_end;
        logic is_dot;
        logic is_star;
        logic is_hyphen;
        logic is_ldh;
        logic is_forbidden;
    } t_cls;

endpackage

// ----- design/dhv_front.sv -----
module dhv_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_char,
    input  logic          i_is_end,
    output logic          o_valid,
    input  logic          i_ready,
    output dhv_pkg::t_cls o_cls
);
    import dhv_pkg::*;

    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_HYPHEN = 8'h2d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_ASCII_MAX = 8'h7f;

    logic r_valid;
    t_cls r_cls;
    t_cls w_cls;

    always_comb begin
        w_cls.is_end    = i_is_end;
        w_cls.is_dot    = !i_is_end && (i_char == CH_DOT);
        w_cls.is_star   = !i_is_end && (i_char == CH_STAR);
        w_cls.is_hyphen = !i_is_end && (i_char == CH_HYPHEN);
        w_cls.is_ldh    = !i_is_end && (((i_char >= 8'h61) && (i_char <= 8'h7a)) ||
                                        ((i_char >= 8'h41) && (i_char <= 8'h5a)) ||
                                        ((i_char >= 8'h30) && (i_char <= 8'h39)) ||
                                        (i_char == CH_HYPHEN));
        w_cls.is_forbidden = !i_is_end && ((i_char == CH_COMMA) || (i_char == CH_SEMI) ||
                                           (i_char == CH_AT) || (i_char == CH_COLON) ||
                                           (i_char == CH_SPACE) ||
                                           ((i_char >= CH_TAB) && (i_char <= CH_CR)) ||
                                           (i_char > CH_ASCII_MAX));
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cls <= w_cls;
        end
    end

endmodule

// ----- design/dhv_fifo.sv -----
module dhv_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  dhv_pkg::t_cls i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output dhv_pkg::t_cls o_pop_data
);
    import dhv_pkg::*;

    t_cls       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- design/dhv_back.sv -----
`include "assert_macros.svh"
module dhv_back #(
    parameter int MAX_LABEL = 63,
    parameter int MAX_NAME  = 255
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dhv_pkg::t_cls    i_cls,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic             o_valid_res,
    output dhv_pkg::t_reason o_reason
);
    import dhv_pkg::*;

    localparam int LW = $clog2(MAX_LABEL + 2);
    localparam int NW = $clog2(MAX_NAME + 2);

    t_phase        r_phase, n_phase;
    logic [NW-1:0] r_name_count, n_name_count;
    logic [LW-1:0] r_label_count, n_label_count;
    logic          r_bad_char, n_bad_char;
    logic          r_form_error, n_form_error;
    logic          r_first_long, n_first_long;
    logic          r_label_bad, n_label_bad;
    logic          r_first_hyphen, n_first_hyphen;
    logic          r_prev_hyphen, n_prev_hyphen;
    logic          r_prev_dot, n_prev_dot;
    logic          r_wild_dot, n_wild_dot;
    t_reason       r_first_fail, n_first_fail;
    logic          r_out_valid;
    t_reason       r_out_reason;

    logic          w_consume;
    logic          w_label_long;
    t_reason       w_close_reason;
    t_reason       w_fin_reason;
    t_reason       w_fail_all;
    t_phase        w_eff_phase;

    assign o_ready   = !i_cls.is_end || !r_out_valid || i_res_ready;
    assign w_consume = i_valid && o_ready;

    assign w_label_long = (r_label_count > LW'(MAX_LABEL));

    // verdict on the label being closed
    always_comb begin
        priority if (r_label_count == '0) begin
            w_close_reason = REASON_FORM;
        end else if (w_label_long) begin
            w_close_reason = REASON_LABEL_LONG;
        end else if (r_first_hyphen || r_prev_hyphen || r_label_bad) begin
            w_close_reason = REASON_FORM;
        end else begin
            w_close_reason = REASON_OK;
        end
    end

    assign w_fail_all = (r_first_fail != REASON_OK) ? r_first_fail : w_close_reason;

    // verdict on the terminator
    always_comb begin
        priority if ((r_phase == PH_START) || r_bad_char) begin
            w_fin_reason = REASON_FORM;
        end else if (r_name_count > NW'(MAX_NAME)) begin
            w_fin_reason = REASON_NAME_LONG;
        end else if ((r_phase == PH_STAR) || (r_phase == PH_BROKEN) || r_form_error) begin
            w_fin_reason = REASON_FORM;
        end else if (r_phase == PH_WILD) begin
            w_fin_reason = r_wild_dot ? w_fail_all : REASON_FORM;
        end else if (r_first_long || ((r_phase == PH_FIRST) && w_label_long)) begin
            w_fin_reason = REASON_LABEL_LONG;
        end else if (r_prev_dot) begin
            w_fin_reason = REASON_FORM;
        end else begin
            w_fin_reason = w_fail_all;
        end
    end

    assign w_eff_phase = ((r_phase == PH_START) && !i_cls.is_star) ? PH_FIRST : r_phase;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_consume) begin
            if (i_cls.is_end) begin
                n_phase = PH_START;
            end else begin
                unique case (r_phase)
                    PH_START:  n_phase = i_cls.is_star ? PH_STAR :
                                         (i_cls.is_dot ? PH_REST : PH_FIRST);
                    PH_STAR:   n_phase = i_cls.is_dot ? PH_WILD : PH_BROKEN;
                    PH_FIRST:  n_phase = i_cls.is_dot ? PH_REST : PH_FIRST;
                    PH_WILD:   n_phase = PH_WILD;
                    PH_REST:   n_phase = PH_REST;
                    PH_BROKEN: n_phase = PH_BROKEN;
                    default:   n_phase = r_phase;
                endcase
            end
        end
    end

    // counters and flags
    always_comb begin
        n_name_count   = r_name_count;
        n_label_count  = r_label_count;
        n_bad_char     = r_bad_char;
        n_form_error   = r_form_error;
        n_first_long   = r_first_long;
        n_label_bad    = r_label_bad;
        n_first_hyphen = r_first_hyphen;
        n_prev_hyphen  = r_prev_hyphen;
        n_prev_dot     = r_prev_dot;
        n_wild_dot     = r_wild_dot;
        n_first_fail   = r_first_fail;
        if (w_consume) begin
            if (i_cls.is_end) begin
                n_name_count   = '0;
                n_label_count  = '0;
                n_bad_char     = 1'b0;
                n_form_error   = 1'b0;
                n_first_long   = 1'b0;
                n_label_bad    = 1'b0;
                n_first_hyphen = 1'b0;
                n_prev_hyphen  = 1'b0;
                n_prev_dot     = 1'b0;
                n_wild_dot     = 1'b0;
                n_first_fail   = REASON_OK;
            end else begin
                if (r_name_count <= NW'(MAX_NAME)) begin
                    n_name_count = r_name_count + NW'(1);
                end
                if (i_cls.is_forbidden) begin
                    n_bad_char = 1'b1;
                end
                priority if ((r_phase == PH_START) && i_cls.is_star) begin
                    n_prev_dot = 1'b0;
                end else if (r_phase == PH_STAR) begin
                    if (!i_cls.is_dot) begin
                        n_form_error = 1'b1;
                    end
                    n_prev_dot = i_cls.is_dot;
                end else begin
                    if ((w_eff_phase == PH_WILD) || (w_eff_phase == PH_FIRST) ||
                        (w_eff_phase == PH_REST)) begin
                        if (i_cls.is_dot) begin
                            // label ends here
                            if (w_eff_phase == PH_WILD) begin
                                n_wild_dot = 1'b1;
                            end
                            if ((w_eff_phase == PH_FIRST) && w_label_long) begin
                                n_first_long = 1'b1;
                            end
                            if (r_first_fail == REASON_OK) begin
                                n_first_fail = w_close_reason;
                            end
                            n_label_count  = '0;
                            n_label_bad    = 1'b0;
                            n_first_hyphen = 1'b0;
                            n_prev_hyphen  = 1'b0;
                        end else begin
                            if (r_label_count == '0) begin
                                n_first_hyphen = i_cls.is_hyphen;
                            end
                            if (!w_label_long) begin
                                n_label_count = r_label_count + LW'(1);
                            end
                            if (!i_cls.is_ldh) begin
                                n_label_bad = 1'b1;
                            end
                            n_prev_hyphen = i_cls.is_hyphen;
                        end
                    end
                    n_prev_dot = i_cls.is_dot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_START;
            r_name_count   <= '0;
            r_label_count  <= '0;
            r_bad_char     <= 1'b0;
            r_form_error   <= 1'b0;
            r_first_long   <= 1'b0;
            r_label_bad    <= 1'b0;
            r_first_hyphen <= 1'b0;
            r_prev_hyphen  <= 1'b0;
            r_prev_dot     <= 1'b0;
            r_wild_dot     <= 1'b0;
            r_first_fail   <= REASON_OK;
            r_out_valid    <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_name_count   <= n_name_count;
            r_label_count  <= n_label_count;
            r_bad_char     <= n_bad_char;
            r_form_error   <= n_form_error;
            r_first_long   <= n_first_long;
            r_label_bad    <= n_label_bad;
            r_first_hyphen <= n_first_hyphen;
            r_prev_hyphen  <= n_prev_hyphen;
            r_prev_dot     <= n_prev_dot;
            r_wild_dot     <= n_wild_dot;
            r_first_fail   <= n_first_fail;
            if (w_consume && i_cls.is_end) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && i_cls.is_end) begin
            r_out_reason <= w_fin_reason;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_reason    = r_out_reason;
    assign o_valid_res = (r_out_reason == REASON_OK);

    `ASSERT_NEXT(a_end_restarts, i_clk, i_rst_n, w_consume && i_cls.is_end,
        (r_phase == PH_START) && (r_name_count == '0) && (r_first_fail == REASON_OK),
        "state not cleared after terminator")
    `ASSERT_ALWAYS(a_label_sat, i_clk, i_rst_n, r_label_count <= LW'(MAX_LABEL + 1),
        "label count beyond saturation")
    `ASSERT_ALWAYS(a_broken_form, i_clk, i_rst_n, (r_phase == PH_BROKEN) == r_form_error,
        "broken wildcard phase and form error disagree")
    `ASSERT_IMPLIES(a_first_long_rest, i_clk, i_rst_n, r_first_long, r_phase == PH_REST,
        "first label flagged long outside later labels")

endmodule

// ----- design/dns_hostname_validator.sv -----
// hostname syntax checker (letter, digit, hyphen rule)
// input stream s_axis: one byte of the name per transaction in tdata, then one
//   terminator transaction with tlast high; tdata of the terminator is ignored
// output stream m_axis: one transaction per terminator; tdata[1:0] is the reason
//   (0 ok, 1 bad form or character, 2 name too long, 3 label too long) and
//   tuser is 1 when the name is acceptable
// throughput: one transaction per cycle while m_axis takes results, names may
//   follow each other with no gap; each byte only updates a few counters and
//   flags in the checker
// path: a terminator passes the input register and the two-entry queue, and
//   its result is offered from the output register
// stall: while a result waits on m_axis the front end and queue keep taking
//   bytes; only a second terminator is held in the queue until the result goes
// reset: synchronous, active low; clears the pipeline, queue and checker state
//   so the next byte starts a new name
module dns_hostname_validator #(
    parameter int MAX_LABEL = 63,
    parameter int MAX_NAME  = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] character
    input  logic       s_axis_tlast,  // is_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [1:0] reason, [7:2] zero
    output logic       m_axis_tuser   // [0] valid_res
);
    import dhv_pkg::*;

    logic    w_front_valid;
    logic    w_front_ready;
    t_cls    w_front_cls;
    logic    w_queue_valid;
    logic    w_queue_ready;
    t_cls    w_queue_cls;
    t_reason w_reason;

    // classify each byte and register it
    dhv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_char   (s_axis_tdata),
        .i_is_end (s_axis_tlast),
        .o_valid  (w_front_valid),
        .i_ready  (w_front_ready),
        .o_cls    (w_front_cls)
    );

    // decouples the front end from a stalled checker
    dhv_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_data  (w_front_cls),
        .o_pop_valid  (w_queue_valid),
        .i_pop_ready  (w_queue_ready),
        .o_pop_data   (w_queue_cls)
    );

    // name walk, verdict and output register
    dhv_back #(
        .MAX_LABEL (MAX_LABEL),
        .MAX_NAME  (MAX_NAME)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_queue_valid),
        .o_ready     (w_queue_ready),
        .i_cls       (w_queue_cls),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_valid_res (m_axis_tuser),
        .o_reason    (w_reason)
    );

    assign m_axis_tdata = {6'd0, w_reason};

endmodule
